// ===== hw/rtl/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV light color converter package
// Field widths, attribute codes, fixed-point constants and the level and hue
// lookup tables shared by the channel interfaces and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hslc_pkg;

    // Field widths
    localparam int unsigned REQ_W = 3;
    localparam int unsigned EP_W  = 16;
    localparam int unsigned VAL_W = 8;
    localparam int unsigned CH_W  = 8;

    // Fixed point: fractions in Q1.16, magnitudes up to 65794 need 17 bits
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned Q_W      = 17;
    localparam int unsigned UNIT_Q16 = 65536;
    localparam int unsigned SCALE_IN = 254;
    localparam int unsigned SECTORS  = 6;
    localparam int unsigned SEC_W    = 3;

    // Digit-serial multiplier: 4-bit digits over a 20-bit multiplier word
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned DIGITS   = 5;
    localparam int unsigned MPLIER_W = DIGIT_W * DIGITS;
    localparam int unsigned SUM_W    = Q_W + DIGIT_W;
    localparam int unsigned CNT_W    = $clog2(DIGITS);
    localparam int unsigned LANES    = 3;

    // Attribute codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ON_OFF     = 3'd0,
        REQ_BRIGHTNESS = 3'd1,
        REQ_HUE        = 3'd2,
        REQ_SATURATION = 3'd3
    } t_req_type;

    // Hue sectors, named by the primaries they span
    typedef enum logic [SEC_W-1:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    typedef logic [255:0][Q_W-1:0]          t_level_tbl;
    typedef logic [255:0][SEC_W+FRAC_W-1:0] t_hue_tbl;

    // Level on a 0..254 scale as a Q1.16 fraction
    function automatic t_level_tbl build_level_tbl();
        t_level_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = Q_W'((i * UNIT_Q16) / SCALE_IN);
        end
        return tbl;
    endfunction

    // Hue on a 0..254 scale as {sector, fraction within the sector}
    function automatic t_hue_tbl build_hue_tbl();
        t_hue_tbl tbl;
        int       h6;
        int       sec;
        int       frac;
        for (int i = 0; i < 256; i++) begin
            h6   = i * SECTORS;
            sec  = (h6 / SCALE_IN) % SECTORS;
            frac = ((h6 % SCALE_IN) * UNIT_Q16) / SCALE_IN;
            tbl[i] = {SEC_W'(sec), FRAC_W'(frac)};
        end
        return tbl;
    endfunction

    localparam t_level_tbl LEVEL_TBL = build_level_tbl();
    localparam t_hue_tbl   HUE_TBL   = build_hue_tbl();

endpackage

`default_nettype wire

// ===== hw/rtl/hslc_in_if.sv =====
// ----------------------------------------------------------------------------
// Attribute write channel
// Valid/ready channel that carries one attribute write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hslc_in_if;

    logic                         valid;
    logic                         ready;
    logic [hslc_pkg::REQ_W-1:0]   req_type;
    logic                         is_pre_update;
    logic [hslc_pkg::EP_W-1:0]    target_endpoint;
    logic [hslc_pkg::VAL_W-1:0]   attr_value;

    modport source (
        output valid, req_type, is_pre_update, target_endpoint, attr_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, is_pre_update, target_endpoint, attr_value,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/hslc_out_if.sv =====
// ----------------------------------------------------------------------------
// RGB result channel
// Valid/ready channel that carries one RGB triple per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hslc_out_if;

    logic                        valid;
    logic                        ready;
    logic [hslc_pkg::CH_W-1:0]   red;
    logic [hslc_pkg::CH_W-1:0]   green;
    logic [hslc_pkg::CH_W-1:0]   blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/hsv_light_color_converter.sv =====
// ----------------------------------------------------------------------------
// HSV light color converter
// Stores hue, saturation, brightness and on/off from attribute writes and
// emits the matching RGB triple through a digit-serial fixed-point datapath.
// ----------------------------------------------------------------------------
// A write that is a pre-update, addresses the configured endpoint and names
// one of the four attributes updates the stored level and yields one RGB beat
// after a setup step, two passes through the three shared shift-add
// multiplier lanes (4-bit digits of a 20-bit multiplier word), a step
// between the passes and a final step to form the result. The input is ready
// again in the cycle after the result is loaded into the output register, so
// no further write is taken until the result of one that takes effect is
// loaded. A result waiting on the sink does not block the next write; only
// the result after it waits in the final step until the sink takes the first.
// Any other write is accepted while the block is idle and yields nothing.
// Channels come out zero when the light is off or brightness is zero.
`default_nettype none

module hsv_light_color_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hslc_pkg::EP_W-1:0]    i_cfg_wdata,
    hslc_in_if.sink                      i_req,
    hslc_out_if.source                   o_rgb
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_MUL1  = 6'b000100,
        S_MID   = 6'b001000,
        S_MUL2  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Return 1.0 - x, clamped at zero
    function automatic logic [hslc_pkg::Q_W-1:0] one_minus(
        input logic [hslc_pkg::Q_W-1:0] x
    );
        logic [hslc_pkg::Q_W:0] d;
        d = (hslc_pkg::Q_W + 1)'(hslc_pkg::UNIT_Q16) - {1'b0, x};
        return d[hslc_pkg::Q_W] ? '0 : d[hslc_pkg::Q_W-1:0];
    endfunction

    // Scale a Q1.16 value to 0..255 and saturate
    function automatic logic [hslc_pkg::CH_W-1:0] to_channel(
        input logic [hslc_pkg::Q_W-1:0] x
    );
        logic [hslc_pkg::Q_W+hslc_pkg::CH_W-1:0] scaled;
        scaled = {x, {hslc_pkg::CH_W{1'b0}}} - (hslc_pkg::Q_W + hslc_pkg::CH_W)'(x);
        if (scaled[hslc_pkg::Q_W+hslc_pkg::CH_W-1:hslc_pkg::FRAC_W+hslc_pkg::CH_W] != '0) begin
            return '1;
        end
        return scaled[hslc_pkg::FRAC_W+hslc_pkg::CH_W-1:hslc_pkg::FRAC_W];
    endfunction

    // Control
    t_state                         r_state;
    t_state                         n_state;
    logic [hslc_pkg::CNT_W-1:0]     r_cnt;
    logic [hslc_pkg::CNT_W-1:0]     n_cnt;
    logic                           r_out_valid;

    // Stored attributes and configuration
    logic [hslc_pkg::EP_W-1:0]      r_endpoint_id;
    logic [hslc_pkg::VAL_W-1:0]     r_hue;
    logic [hslc_pkg::VAL_W-1:0]     r_sat;
    logic [hslc_pkg::VAL_W-1:0]     r_bri;
    logic                           r_light_on;

    // Datapath
    logic [hslc_pkg::MPLIER_W-1:0]  r_mplier;
    logic [hslc_pkg::Q_W-1:0]       r_mcand [hslc_pkg::LANES];
    logic [hslc_pkg::Q_W-1:0]       r_acc   [hslc_pkg::LANES];
    logic [hslc_pkg::MPLIER_W-1:0]  r_low   [hslc_pkg::LANES];
    logic [hslc_pkg::SEC_W-1:0]     r_sector;
    logic [hslc_pkg::CH_W-1:0]      r_red;
    logic [hslc_pkg::CH_W-1:0]      r_green;
    logic [hslc_pkg::CH_W-1:0]      r_blue;

    logic                           w_req_fire;
    logic                           w_known;
    logic                           w_write;
    logic                           w_last;
    logic                           w_out_free;
    logic                           w_lit;
    logic [hslc_pkg::DIGIT_W-1:0]   w_digit;
    logic [hslc_pkg::SUM_W-1:0]     w_sum   [hslc_pkg::LANES];
    logic [hslc_pkg::Q_W-1:0]       w_res   [hslc_pkg::LANES];
    logic [hslc_pkg::Q_W-1:0]       w_v;
    logic [hslc_pkg::Q_W-1:0]       w_s;
    logic [hslc_pkg::FRAC_W-1:0]    w_f;
    logic [hslc_pkg::SEC_W-1:0]     w_sec;
    logic [hslc_pkg::Q_W-1:0]       w_r_q;
    logic [hslc_pkg::Q_W-1:0]       w_g_q;
    logic [hslc_pkg::Q_W-1:0]       w_b_q;

    // Decode the incoming beat
    assign w_req_fire = i_req.valid && i_req.ready;

    always_comb begin
        unique case (i_req.req_type) inside
            hslc_pkg::REQ_ON_OFF, hslc_pkg::REQ_BRIGHTNESS,
            hslc_pkg::REQ_HUE, hslc_pkg::REQ_SATURATION: begin
                w_known = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign w_write = w_req_fire && i_req.is_pre_update && w_known
                   && (i_req.target_endpoint == r_endpoint_id);

    // Table lookups from the stored levels
    assign w_v                = hslc_pkg::LEVEL_TBL[r_bri];
    assign w_s                = hslc_pkg::LEVEL_TBL[r_sat];
    assign {w_sec, w_f}       = hslc_pkg::HUE_TBL[r_hue];
    assign w_lit              = r_light_on && (r_bri != '0);

    // Shift-add lanes: add one digit's partial product, drop a digit
    assign w_digit = r_mplier[hslc_pkg::DIGIT_W-1:0];

    always_comb begin
        for (int i = 0; i < hslc_pkg::LANES; i++) begin
            w_sum[i] = hslc_pkg::SUM_W'(r_acc[i])
                     + hslc_pkg::SUM_W'(r_mcand[i]) * hslc_pkg::SUM_W'(w_digit);
            w_res[i] = {r_acc[i][hslc_pkg::Q_W-(hslc_pkg::MPLIER_W-hslc_pkg::FRAC_W)-1:0],
                        r_low[i][hslc_pkg::MPLIER_W-1:hslc_pkg::FRAC_W]};
        end
    end

    // Route v, p, q, t to the channels by sector
    always_comb begin
        case (r_sector)
            hslc_pkg::SEC_R_Y: begin
                w_r_q = w_v;      w_g_q = w_res[2]; w_b_q = w_res[0];
            end
            hslc_pkg::SEC_Y_G: begin
                w_r_q = w_res[1]; w_g_q = w_v;      w_b_q = w_res[0];
            end
            hslc_pkg::SEC_G_C: begin
                w_r_q = w_res[0]; w_g_q = w_v;      w_b_q = w_res[2];
            end
            hslc_pkg::SEC_C_B: begin
                w_r_q = w_res[0]; w_g_q = w_res[1]; w_b_q = w_v;
            end
            hslc_pkg::SEC_B_M: begin
                w_r_q = w_res[2]; w_g_q = w_res[0]; w_b_q = w_v;
            end
            default: begin
                w_r_q = w_v;      w_g_q = w_res[0]; w_b_q = w_res[1];
            end
        endcase
    end

    // Sequencer
    assign w_last     = (r_cnt == hslc_pkg::CNT_W'(hslc_pkg::DIGITS - 1));
    assign w_out_free = !r_out_valid || o_rgb.ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_write) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = S_MID;
                end
            end
            S_MID: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (w_last && (r_state == S_MUL1 || r_state == S_MUL2)) ? '0 : n_cnt;
        end
    end

    // Configuration and stored attributes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_endpoint_id <= '0;
            r_hue         <= '0;
            r_sat         <= '0;
            r_bri         <= hslc_pkg::VAL_W'(hslc_pkg::SCALE_IN);
            r_light_on    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_endpoint_id <= i_cfg_wdata;
            end
            if (w_write) begin
                unique case (i_req.req_type)
                    hslc_pkg::REQ_ON_OFF:     r_light_on <= i_req.attr_value[0];
                    hslc_pkg::REQ_BRIGHTNESS: r_bri      <= i_req.attr_value;
                    hslc_pkg::REQ_HUE:        r_hue      <= i_req.attr_value;
                    hslc_pkg::REQ_SATURATION: r_sat      <= i_req.attr_value;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Multiplier lanes: pass one forms s*f and s*(1-f), pass two v*(1-x)
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            S_SETUP: begin
                r_mplier   <= hslc_pkg::MPLIER_W'(w_s);
                r_mcand[0] <= hslc_pkg::Q_W'(w_f);
                r_mcand[1] <= hslc_pkg::Q_W'(hslc_pkg::UNIT_Q16) - hslc_pkg::Q_W'(w_f);
                r_mcand[2] <= '0;
                r_sector   <= w_sec;
                for (int i = 0; i < hslc_pkg::LANES; i++) begin
                    r_acc[i] <= '0;
                end
            end
            S_MID: begin
                r_mplier   <= hslc_pkg::MPLIER_W'(w_v);
                r_mcand[0] <= one_minus(w_s);
                r_mcand[1] <= one_minus(w_res[0]);
                r_mcand[2] <= one_minus(w_res[1]);
                for (int i = 0; i < hslc_pkg::LANES; i++) begin
                    r_acc[i] <= '0;
                end
            end
            S_MUL1, S_MUL2: begin
                r_mplier <= r_mplier >> hslc_pkg::DIGIT_W;
                for (int i = 0; i < hslc_pkg::LANES; i++) begin
                    r_acc[i] <= w_sum[i][hslc_pkg::SUM_W-1:hslc_pkg::DIGIT_W];
                    r_low[i] <= {w_sum[i][hslc_pkg::DIGIT_W-1:0],
                                 r_low[i][hslc_pkg::MPLIER_W-1:hslc_pkg::DIGIT_W]};
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load the triple once the sink side is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_red   <= w_lit ? to_channel(w_r_q) : '0;
            r_green <= w_lit ? to_channel(w_g_q) : '0;
            r_blue  <= w_lit ? to_channel(w_b_q) : '0;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rgb.valid = r_out_valid;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

    // A new beat appears only as the sequencer finishes
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the final step");

    // Every multiplier digit is consumed by the end of a pass
    a_mplier_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID || r_state == S_DONE) |-> (r_mplier == '0))
        else $error("multiplier digits left after a pass");

    // The digit counter stays within one pass
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1 || r_state == S_MUL2)
            |-> (r_cnt < hslc_pkg::CNT_W'(hslc_pkg::DIGITS)))
        else $error("digit counter out of range");

endmodule

`default_nettype wire

// ===== tb/sv/hsv_light_color_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV light color converter checker
// Watches the attribute write and RGB channels, keeps its own copy of the
// light state and endpoint, predicts the RGB beat of every write that takes
// effect and compares the beats in order, channel by channel.
// ----------------------------------------------------------------------------
module hsv_light_color_converter_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hslc_pkg::EP_W-1:0] i_cfg_wdata,
    hslc_in_if                        i_req,
    hslc_out_if                       i_rgb,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_write_count,
    output int                        o_update_count,
    output int                        o_beat_count
);

    // Signed fixed-point constants; Q1.16 with truncating division
    localparam longint Q16_ONE      = 65536;
    localparam longint LEVEL_SCALE  = 254;
    localparam longint CH_SCALE     = 255;
    localparam longint CH_MAX       = 255;
    localparam longint SECTOR_COUNT = 6;
    localparam logic [hslc_pkg::VAL_W-1:0] RESET_BRIGHTNESS = 8'd254;

    typedef struct packed {
        logic [hslc_pkg::CH_W-1:0] red;
        logic [hslc_pkg::CH_W-1:0] green;
        logic [hslc_pkg::CH_W-1:0] blue;
    } t_rgb_beat;

    t_rgb_beat                  rgb_expect_q[$];
    logic [hslc_pkg::EP_W-1:0]  light_endpoint;
    logic [hslc_pkg::VAL_W-1:0] hue_level;
    logic [hslc_pkg::VAL_W-1:0] sat_level;
    logic [hslc_pkg::VAL_W-1:0] bright_level;
    logic                       light_on;
    int                         fail_cnt   = 0;
    int                         write_cnt  = 0;
    int                         update_cnt = 0;
    int                         beat_cnt   = 0;

    // Scale a Q1.16 level to a channel and clamp to 0..255
    function automatic logic [hslc_pkg::CH_W-1:0] q16_to_channel(input longint x);
        longint c;
        c = x * CH_SCALE / Q16_ONE;
        if (c < 0) begin
            c = 0;
        end
        if (c > CH_MAX) begin
            c = CH_MAX;
        end
        return hslc_pkg::CH_W'(c);
    endfunction

    // Six-sector HSV conversion of levels on a 0..254 scale
    function automatic t_rgb_beat predict_rgb(input int hue, input int sat,
                                              input int bright, input logic on);
        longint    v;
        longint    s;
        longint    h6;
        longint    f;
        longint    p;
        longint    q;
        longint    t;
        longint    r;
        longint    g;
        longint    b;
        t_rgb_beat beat;
        v = bright * Q16_ONE / LEVEL_SCALE;
        s = sat * Q16_ONE / LEVEL_SCALE;
        if (!on || bright == 0) begin
            return '0;
        end
        if (sat == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            h6 = hue * SECTOR_COUNT;
            f  = (h6 % LEVEL_SCALE) * Q16_ONE / LEVEL_SCALE;
            p  = v * (Q16_ONE - s) / Q16_ONE;
            q  = v * (Q16_ONE - s * f / Q16_ONE) / Q16_ONE;
            t  = v * (Q16_ONE - s * (Q16_ONE - f) / Q16_ONE) / Q16_ONE;
            // hue 254 and 255 land past the last sector and wrap to red-yellow
            case (hslc_pkg::t_sector'(hslc_pkg::SEC_W'((h6 / LEVEL_SCALE) % SECTOR_COUNT)))
                hslc_pkg::SEC_R_Y: begin r = v; g = t; b = p; end
                hslc_pkg::SEC_Y_G: begin r = q; g = v; b = p; end
                hslc_pkg::SEC_G_C: begin r = p; g = v; b = t; end
                hslc_pkg::SEC_C_B: begin r = p; g = q; b = v; end
                hslc_pkg::SEC_B_M: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
        end
        beat.red   = q16_to_channel(r);
        beat.green = q16_to_channel(g);
        beat.blue  = q16_to_channel(b);
        return beat;
    endfunction

    function automatic int channel_mismatch(input string name,
                                            input logic [hslc_pkg::CH_W-1:0] want,
                                            input logic [hslc_pkg::CH_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track state on every beat and match RGB beats against predictions
    always @(posedge i_clk) begin : monitor
        t_rgb_beat seen;
        t_rgb_beat want;
        logic      acted;
        if (!i_rst_n) begin
            rgb_expect_q.delete();
            light_endpoint = '0;
            hue_level      = '0;
            sat_level      = '0;
            bright_level   = RESET_BRIGHTNESS;
            light_on       = 1'b0;
        end else begin
            if (i_cfg_we) begin
                light_endpoint = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                write_cnt++;
                acted = i_req.is_pre_update && (i_req.target_endpoint == light_endpoint);
                if (acted) begin
                    case (i_req.req_type)
                        hslc_pkg::REQ_ON_OFF:     light_on     = i_req.attr_value[0];
                        hslc_pkg::REQ_BRIGHTNESS: bright_level = i_req.attr_value;
                        hslc_pkg::REQ_HUE:        hue_level    = i_req.attr_value;
                        hslc_pkg::REQ_SATURATION: sat_level    = i_req.attr_value;
                        default:                  acted        = 1'b0;
                    endcase
                end
                if (acted) begin
                    update_cnt++;
                    rgb_expect_q.push_back(predict_rgb(hue_level, sat_level,
                                                       bright_level, light_on));
                end
            end
            if (i_rgb.valid && i_rgb.ready) begin
                beat_cnt++;
                seen.red   = i_rgb.red;
                seen.green = i_rgb.green;
                seen.blue  = i_rgb.blue;
                if (rgb_expect_q.size() == 0) begin
                    $display("%0t: RGB beat %0d/%0d/%0d with none expected, expected nothing",
                             $time, seen.red, seen.green, seen.blue);
                    fail_cnt++;
                end else begin
                    want = rgb_expect_q.pop_front();
                    if (channel_mismatch("red", want.red, seen.red) +
                        channel_mismatch("green", want.green, seen.green) +
                        channel_mismatch("blue", want.blue, seen.blue) != 0) begin
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending      <= rgb_expect_q.size();
        o_fail_count   <= fail_cnt;
        o_write_count  <= write_cnt;
        o_update_count <= update_cnt;
        o_beat_count   <= beat_cnt;
    end

endmodule

// ===== tb/sv/hsv_light_color_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV light color converter testbench
// Drives attribute writes and endpoint settings into the converter with
// random gaps and output stalls, including one long output hold-off, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module hsv_light_color_converter_tb;

    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 11;
    localparam int     IDLE_MAX        = 6;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     DRAIN_CYCLES    = 32;
    localparam int     PHASES          = 6;
    localparam int     PHASE_UPDATES   = 100;
    localparam longint TIMEOUT_NS      = 2_000_000;

    localparam logic [hslc_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd4;
    localparam logic [hslc_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam logic [hslc_pkg::EP_W-1:0]  EP_MAX        = '1;
    localparam logic [hslc_pkg::EP_W-1:0]  EP_MSB        = 16'h8000;
    localparam logic [hslc_pkg::VAL_W-1:0] VAL_MAX       = '1;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [hslc_pkg::EP_W-1:0] i_cfg_wdata;

    hslc_in_if  req_ch ();
    hslc_out_if rgb_ch ();

    int                        fail_count;
    int                        pending;
    int                        write_count;
    int                        update_count;
    int                        beat_count;
    int                        send_gap_max      = 3;
    int                        rgb_stall_max     = 3;
    logic                      hold_off_req      = 1'b0;
    logic [hslc_pkg::EP_W-1:0] light_endpoint    = '0;
    int                        endpoint_settings = 1;

    hsv_light_color_converter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rgb       (rgb_ch)
    );

    hsv_light_color_converter_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req          (req_ch),
        .i_rgb          (rgb_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_write_count  (write_count),
        .o_update_count (update_count),
        .o_beat_count   (beat_count)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Offer one write after a random gap and hold it until it is taken
    task automatic send_write(input logic [hslc_pkg::REQ_W-1:0] kind, input logic pre,
                              input logic [hslc_pkg::EP_W-1:0] ep,
                              input logic [hslc_pkg::VAL_W-1:0] val);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.is_pre_update   <= pre;
        req_ch.target_endpoint <= ep;
        req_ch.attr_value      <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Change the endpoint only once the block has drained
    task automatic write_endpoint(input logic [hslc_pkg::EP_W-1:0] ep);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ep;
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        light_endpoint  = ep;
        endpoint_settings++;
    endtask

    // Mostly uniform levels, with the scale edges now and then
    function automatic logic [hslc_pkg::VAL_W-1:0] pick_level();
        if ($urandom_range(0, 7) != 0) begin
            return hslc_pkg::VAL_W'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return VAL_MAX;
        endcase
    endfunction

    // Mostly writes that take effect, the rest ignored in one of three ways
    task automatic run_random_phase(input int updates);
        int                         acted;
        int                         roll;
        logic [hslc_pkg::REQ_W-1:0] kind;
        logic                       pre;
        logic [hslc_pkg::EP_W-1:0]  ep;
        logic [hslc_pkg::VAL_W-1:0] val;
        acted = 0;
        while (acted < updates) begin
            kind = hslc_pkg::REQ_W'($urandom_range(hslc_pkg::REQ_ON_OFF,
                                                   hslc_pkg::REQ_SATURATION));
            pre  = 1'b1;
            ep   = light_endpoint;
            val  = pick_level();
            // keep the light on most of the time so colors show
            if (kind == hslc_pkg::REQ_ON_OFF && $urandom_range(0, 3) != 0) begin
                val[0] = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                pre = 1'b0;
            end else if (roll < 14) begin
                ep = hslc_pkg::EP_W'($urandom);
            end else if (roll < 20) begin
                kind = hslc_pkg::REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            end
            if (pre && ep == light_endpoint && kind <= hslc_pkg::REQ_SATURATION) begin
                acted++;
            end
            send_write(kind, pre, ep, val);
        end
        req_ch.valid <= 1'b0;
    endtask

    // Accept RGB beats after random stalls; one long hold-off on request
    initial begin : rgb_sink
        int stall;
        rgb_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_OFF_CYCLES;
            end else begin
                stall = $urandom_range(0, rgb_stall_max);
            end
            if (stall > 0) begin
                rgb_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rgb_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rgb_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [hslc_pkg::EP_W-1:0] next_ep;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_wdata            = '0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = hslc_pkg::REQ_ON_OFF;
        req_ch.is_pre_update   = 1'b0;
        req_ch.target_endpoint = '0;
        req_ch.attr_value      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: light off, then every hue sector, scale edges, ignored writes
        send_write(hslc_pkg::REQ_ON_OFF, 1'b1, '0, 8'hFE);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd43);
        send_write(hslc_pkg::REQ_ON_OFF, 1'b1, '0, VAL_MAX);
        send_write(hslc_pkg::REQ_SATURATION, 1'b1, '0, 8'd254);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd85);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd127);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd170);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd212);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd254);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, VAL_MAX);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, '0);
        send_write(hslc_pkg::REQ_SATURATION, 1'b1, '0, VAL_MAX);
        send_write(hslc_pkg::REQ_HUE, 1'b1, '0, 8'd100);
        send_write(hslc_pkg::REQ_BRIGHTNESS, 1'b1, '0, VAL_MAX);
        send_write(hslc_pkg::REQ_BRIGHTNESS, 1'b1, '0, '0);
        send_write(hslc_pkg::REQ_BRIGHTNESS, 1'b1, '0, 8'd128);
        send_write(hslc_pkg::REQ_SATURATION, 1'b1, '0, '0);
        send_write(REQ_UNUSED_LO, 1'b1, '0, 8'h55);
        send_write(REQ_UNUSED_HI, 1'b1, '0, 8'hAA);
        send_write(hslc_pkg::REQ_BRIGHTNESS, 1'b0, '0, 8'd10);
        send_write(hslc_pkg::REQ_HUE, 1'b1, EP_MAX, 8'd20);
        send_write(hslc_pkg::REQ_ON_OFF, 1'b1, '0, 8'h00);
        req_ch.valid <= 1'b0;

        // Random phases, each with its own endpoint and idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin next_ep = EP_MAX; send_gap_max = 0; rgb_stall_max = 0; end
                1: begin next_ep = hslc_pkg::EP_W'($urandom); send_gap_max = IDLE_MAX;
                         rgb_stall_max = IDLE_MAX; end
                2: begin next_ep = '0; send_gap_max = 0; rgb_stall_max = IDLE_MAX; end
                3: begin next_ep = EP_MSB; send_gap_max = IDLE_MAX; rgb_stall_max = 0; end
                4: begin next_ep = hslc_pkg::EP_W'($urandom); send_gap_max = IDLE_MAX;
                         rgb_stall_max = IDLE_MAX; end
                default: begin next_ep = hslc_pkg::EP_W'($urandom); send_gap_max = 3;
                               rgb_stall_max = 3; end
            endcase
            write_endpoint(next_ep);
            // back-to-back writes against a stalled output fill the block
            if (ph == 2) begin
                hold_off_req = 1'b1;
            end
            run_random_phase(PHASE_UPDATES);
        end

        // Drain and report
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d attribute writes, %0d taking effect, over %0d endpoint values",
                 write_count, update_count, endpoint_settings);
        $display("compared %0d RGB beats in order, %0d of them wrong", beat_count, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("run timed out");
        $display("status: fail");
        $finish;
    end

endmodule
